[sv/htbd_pkg.sv]
// Shared types and codes for the Huffman tree build and decode block.
// No dependencies; the top level of the block takes names from here.
package htbd_pkg;

  // Command codes carried in the opcode field of an input item.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  // Kinds of result item.
  localparam logic [1:0] KIND_SYMBOL = 2'd0;
  localparam logic [1:0] KIND_BUILT  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // Most coded bits one decode item can carry.
  localparam logic [3:0] MAX_BITS = 4'd8;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_B_FRD,
    ST_B_FCHK,
    ST_B_NEXT,
    ST_PU_START,
    ST_PU_RD,
    ST_PU_CMP,
    ST_PU_FIN,
    ST_M_CHK,
    ST_PO_TOP_RD,
    ST_PO_TOP,
    ST_PO_LOOP,
    ST_PO_L_RD,
    ST_PO_L,
    ST_PO_R_RD,
    ST_PO_R,
    ST_PO_END_RD,
    ST_PO_END,
    ST_M_NODE,
    ST_B_HRD,
    ST_B_HRT,
    ST_B_ROOT,
    ST_B_EMIT,
    ST_D_BIT,
    ST_D_CHK,
    ST_D_EOM,
    ST_FINISH
  } state_t;

endpackage

[sv/htbd_req_if.sv]
// Input channel of the Huffman block: valid, ready and the command item.
// Depends on nothing.
interface htbd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [6:0] symbol_index;
  logic [7:0] freq_value;
  logic [7:0] data_byte;
  logic [3:0] bit_count;
  logic       end_of_message;

  modport source (output valid, opcode, symbol_index, freq_value, data_byte,
                  bit_count, end_of_message, input ready);
  modport sink   (input valid, opcode, symbol_index, freq_value, data_byte,
                  bit_count, end_of_message, output ready);
endinterface

[sv/htbd_rsp_if.sv]
// Result channel of the Huffman block: valid, ready and the result item.
// Depends on nothing.
interface htbd_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [6:0] decoded_symbol;
  logic [6:0] leaf_count;
  logic       garbage;
  logic       last_of_run;

  modport source (output valid, result_kind, decoded_symbol, leaf_count, garbage,
                  last_of_run, input ready);
  modport sink   (input valid, result_kind, decoded_symbol, leaf_count, garbage,
                  last_of_run, output ready);
endinterface

[sv/htbd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module htbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/huffman_tree_build_and_decode.sv]
// Huffman tree build and decode top level.
// Depends on htbd_pkg, htbd_req_if, htbd_rsp_if and htbd_ram.

// The block takes one item at a time. A load item writes one frequency and
// gives no result. A build item sweeps the frequency table, with a heap
// insert for each present symbol, then merges the two smallest heap entries
// until one is left (each removal sifts down the heap, each merge is a
// further insert), and delivers one tree-built item. A decode item makes one
// node read of the node memory per tree step; with a single-symbol tree every
// bit lands on the root leaf and no node read is needed. Results are held one
// deep inside the block so that the last item caused by an input can be
// marked, and an output register lets the block keep working while a result
// waits. Frequencies reset to zero through one valid bit per table entry; no
// clearing pass is needed.
module huffman_tree_build_and_decode #(
  parameter int SYMBOLS   = 128,
  parameter int FREQ_BITS = 8
) (
  input logic        clk,
  input logic        rst,
  htbd_req_if.sink   req,
  htbd_rsp_if.source rsp
);

  localparam int SW    = $clog2(SYMBOLS);
  localparam int NODES = 2 * SYMBOLS;
  localparam int NW    = $clog2(NODES);
  // a merged weight never exceeds (SYMBOLS-1) * max frequency
  localparam int WB    = FREQ_BITS + SW;

  typedef struct packed {
    logic          leaf;
    logic [SW-1:0] sym;
    logic [NW-1:0] left;
    logic [NW-1:0] right;
  } node_t;

  // heap entries carry their weight so a sift needs no node lookup
  typedef struct packed {
    logic [WB-1:0] w;
    logic [NW-1:0] idx;
  } hent_t;

  localparam int NODE_W = $bits(node_t);
  localparam int HENT_W = $bits(hent_t);

  htbd_pkg::state_t state, state_next;

  // memory ports
  logic                 f_we, f_re;
  logic [SW-1:0]        f_waddr, f_raddr;
  logic [FREQ_BITS-1:0] f_wdata, f_rdata;
  logic                 n_we, n_re;
  logic [NW-1:0]        n_waddr, n_raddr;
  node_t                n_wdata, n_rdata;
  logic                 h_we, h_re;
  logic [SW-1:0]        h_waddr, h_raddr;
  hent_t                h_wdata, h_rdata;

  // frequency valid bits stand in for a cleared table
  logic [SYMBOLS-1:0]   fvalid;
  logic                 fvalid_q;

  // build state
  logic [SW:0]          s;
  logic [NW-1:0]        node_count;
  logic [SW-1:0]        heap_size;
  logic [SW-1:0]        leaves;
  logic                 in_merge;
  logic                 pop_second;
  hent_t                pu_ent;
  logic [SW-1:0]        pu_i;
  logic [SW-1:0]        po_i;
  logic [SW-1:0]        po_end;
  hent_t                po_top, po_lent, ent_a, ent_b;

  // tree and walk state
  logic                 tree_ready;
  logic [NW-1:0]        root;
  node_t                root_rec;
  node_t                cur_rec;
  logic [NW-1:0]        walk_node;
  logic [NW-1:0]        d_child;
  logic [7:0]           dbits;
  logic [3:0]           dcnt;
  logic                 deom;

  // one-deep hold of the newest result
  logic                 pend_valid;
  logic [1:0]           pend_kind;
  logic [6:0]           pend_sym;
  logic [6:0]           pend_leaves;
  logic                 pend_garb;

  // derived control
  logic                 acc;
  logic                 in_range;
  logic [3:0]           sat_bits;
  logic [FREQ_BITS-1:0] fval;
  logic [SW:0]          l2, l2p1, end_x;
  logic                 left_lt, right_lt;
  logic [SW-1:0]        pu_par;
  logic                 par_le;
  logic                 empty;
  logic [NW-1:0]        child;
  logic                 out_free, can_emit;
  logic                 emit_req, flush_req, emit_fire, flush_fire;
  logic [1:0]           emit_kind;
  logic [6:0]           emit_sym;
  logic [6:0]           emit_leaves;
  logic                 emit_garb;
  htbd_pkg::state_t     push_ret;

  htbd_ram #(.WIDTH(FREQ_BITS), .DEPTH(SYMBOLS)) u_freq (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
  );

  htbd_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .re(n_re), .raddr(n_raddr), .rdata(n_rdata)
  );

  htbd_ram #(.WIDTH(HENT_W), .DEPTH(SYMBOLS)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  assign req.ready = (state == htbd_pkg::ST_IDLE);
  assign acc       = req.valid && req.ready;
  assign in_range  = int'(req.symbol_index) < SYMBOLS;
  assign sat_bits  = (req.bit_count > htbd_pkg::MAX_BITS) ? htbd_pkg::MAX_BITS
                                                          : req.bit_count;
  assign fval      = fvalid_q ? f_rdata : '0;

  // heap slot arithmetic: children of the hole, parent of the insert slot
  assign l2       = {po_i, 1'b0};
  assign l2p1     = {po_i, 1'b1};
  assign end_x    = {1'b0, po_end};
  assign left_lt  = l2 < end_x;
  assign right_lt = l2p1 < end_x;
  assign pu_par   = pu_i >> 1;
  assign par_le   = h_rdata.w <= pu_ent.w;

  assign empty    = !tree_ready || (heap_size == '0);
  assign child    = dbits[7] ? cur_rec.right : cur_rec.left;
  assign out_free = !rsp.valid || rsp.ready;
  assign can_emit = !pend_valid || out_free;
  assign push_ret = in_merge ? htbd_pkg::ST_M_CHK : htbd_pkg::ST_B_NEXT;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      htbd_pkg::ST_IDLE: begin
        if (acc) begin
          if (req.opcode == htbd_pkg::OP_BUILD) begin
            state_next = htbd_pkg::ST_B_FRD;
          end else if (req.opcode == htbd_pkg::OP_DECODE) begin
            state_next = htbd_pkg::ST_D_BIT;
          end
        end
      end
      htbd_pkg::ST_B_FRD:  state_next = htbd_pkg::ST_B_FCHK;
      htbd_pkg::ST_B_FCHK: begin
        state_next = (fval != '0) ? htbd_pkg::ST_PU_START : htbd_pkg::ST_B_NEXT;
      end
      htbd_pkg::ST_B_NEXT: begin
        state_next = (s == (SW+1)'(SYMBOLS - 1)) ? htbd_pkg::ST_M_CHK
                                                 : htbd_pkg::ST_B_FRD;
      end
      htbd_pkg::ST_PU_START: begin
        state_next = (heap_size != '0) ? htbd_pkg::ST_PU_RD : htbd_pkg::ST_PU_FIN;
      end
      htbd_pkg::ST_PU_RD: state_next = htbd_pkg::ST_PU_CMP;
      htbd_pkg::ST_PU_CMP: begin
        if (par_le) begin
          state_next = push_ret;
        end else begin
          state_next = (pu_par > SW'(1)) ? htbd_pkg::ST_PU_RD : htbd_pkg::ST_PU_FIN;
        end
      end
      htbd_pkg::ST_PU_FIN: state_next = push_ret;
      htbd_pkg::ST_M_CHK: begin
        if (heap_size > SW'(1)) begin
          state_next = htbd_pkg::ST_PO_TOP_RD;
        end else if (heap_size != '0) begin
          state_next = htbd_pkg::ST_B_HRD;
        end else begin
          state_next = htbd_pkg::ST_B_EMIT;
        end
      end
      htbd_pkg::ST_PO_TOP_RD: state_next = htbd_pkg::ST_PO_TOP;
      htbd_pkg::ST_PO_TOP:    state_next = htbd_pkg::ST_PO_LOOP;
      htbd_pkg::ST_PO_LOOP: begin
        state_next = left_lt ? htbd_pkg::ST_PO_L_RD : htbd_pkg::ST_PO_END_RD;
      end
      htbd_pkg::ST_PO_L_RD: state_next = htbd_pkg::ST_PO_L;
      htbd_pkg::ST_PO_L: begin
        state_next = right_lt ? htbd_pkg::ST_PO_R_RD : htbd_pkg::ST_PO_LOOP;
      end
      htbd_pkg::ST_PO_R_RD:   state_next = htbd_pkg::ST_PO_R;
      htbd_pkg::ST_PO_R:      state_next = htbd_pkg::ST_PO_LOOP;
      htbd_pkg::ST_PO_END_RD: state_next = htbd_pkg::ST_PO_END;
      htbd_pkg::ST_PO_END: begin
        state_next = pop_second ? htbd_pkg::ST_M_NODE : htbd_pkg::ST_PO_TOP_RD;
      end
      htbd_pkg::ST_M_NODE: state_next = htbd_pkg::ST_PU_START;
      htbd_pkg::ST_B_HRD:  state_next = htbd_pkg::ST_B_HRT;
      htbd_pkg::ST_B_HRT:  state_next = htbd_pkg::ST_B_ROOT;
      htbd_pkg::ST_B_ROOT: state_next = htbd_pkg::ST_B_EMIT;
      htbd_pkg::ST_B_EMIT: begin
        if (can_emit) begin
          state_next = htbd_pkg::ST_FINISH;
        end
      end
      htbd_pkg::ST_D_BIT: begin
        if (empty || dcnt == '0) begin
          state_next = htbd_pkg::ST_D_EOM;
        end else if (!root_rec.leaf) begin
          state_next = htbd_pkg::ST_D_CHK;
        end
      end
      htbd_pkg::ST_D_CHK: begin
        if (!n_rdata.leaf || can_emit) begin
          state_next = htbd_pkg::ST_D_BIT;
        end
      end
      htbd_pkg::ST_D_EOM: begin
        if (!deom || can_emit) begin
          state_next = htbd_pkg::ST_FINISH;
        end
      end
      htbd_pkg::ST_FINISH: begin
        if (!pend_valid || out_free) begin
          state_next = htbd_pkg::ST_IDLE;
        end
      end
      default: state_next = htbd_pkg::ST_IDLE;
    endcase
  end

  // memory controls and result requests
  always_comb begin
    f_we        = 1'b0;
    f_waddr     = SW'(req.symbol_index);
    f_wdata     = FREQ_BITS'(req.freq_value);
    f_re        = 1'b0;
    f_raddr     = s[SW-1:0];
    n_we        = 1'b0;
    n_waddr     = node_count;
    n_wdata     = '0;
    n_re        = 1'b0;
    n_raddr     = child;
    h_we        = 1'b0;
    h_waddr     = po_i;
    h_wdata     = h_rdata;
    h_re        = 1'b0;
    h_raddr     = SW'(1);
    emit_req    = 1'b0;
    emit_kind   = htbd_pkg::KIND_SYMBOL;
    emit_sym    = '0;
    emit_leaves = '0;
    emit_garb   = 1'b0;
    flush_req   = 1'b0;
    unique case (state)
      htbd_pkg::ST_IDLE: begin
        f_we = acc && (req.opcode == htbd_pkg::OP_LOAD) && in_range;
      end
      htbd_pkg::ST_B_FRD: f_re = 1'b1;
      htbd_pkg::ST_B_FCHK: begin
        n_we          = (fval != '0);
        n_wdata.leaf  = 1'b1;
        n_wdata.sym   = s[SW-1:0];
      end
      htbd_pkg::ST_PU_RD: begin
        h_re    = 1'b1;
        h_raddr = pu_par;
      end
      htbd_pkg::ST_PU_CMP: begin
        h_we    = 1'b1;
        h_waddr = pu_i;
        h_wdata = par_le ? pu_ent : h_rdata;
      end
      htbd_pkg::ST_PU_FIN: begin
        h_we    = 1'b1;
        h_waddr = pu_i;
        h_wdata = pu_ent;
      end
      htbd_pkg::ST_PO_TOP_RD: h_re = 1'b1;
      htbd_pkg::ST_PO_L_RD: begin
        h_re    = 1'b1;
        h_raddr = l2[SW-1:0];
      end
      htbd_pkg::ST_PO_L: begin
        h_we = !right_lt;
      end
      htbd_pkg::ST_PO_R_RD: begin
        h_re    = 1'b1;
        h_raddr = l2p1[SW-1:0];
      end
      htbd_pkg::ST_PO_R: begin
        // the right child wins only when strictly lighter
        h_we    = 1'b1;
        h_wdata = (h_rdata.w < po_lent.w) ? h_rdata : po_lent;
      end
      htbd_pkg::ST_PO_END_RD: begin
        h_re    = 1'b1;
        h_raddr = po_end;
      end
      htbd_pkg::ST_PO_END: h_we = 1'b1;
      htbd_pkg::ST_M_NODE: begin
        n_we          = 1'b1;
        n_wdata.left  = ent_a.idx;
        n_wdata.right = ent_b.idx;
      end
      htbd_pkg::ST_B_HRD: h_re = 1'b1;
      htbd_pkg::ST_B_HRT: begin
        n_re    = 1'b1;
        n_raddr = h_rdata.idx;
      end
      htbd_pkg::ST_B_EMIT: begin
        emit_req    = 1'b1;
        emit_kind   = htbd_pkg::KIND_BUILT;
        emit_leaves = 7'(leaves);
      end
      htbd_pkg::ST_D_BIT: begin
        if (!empty && dcnt != '0) begin
          if (root_rec.leaf) begin
            emit_req = 1'b1;
            emit_sym = 7'(root_rec.sym);
          end else begin
            n_re = 1'b1;
          end
        end
      end
      htbd_pkg::ST_D_CHK: begin
        emit_req = n_rdata.leaf;
        emit_sym = 7'(n_rdata.sym);
      end
      htbd_pkg::ST_D_EOM: begin
        emit_req  = deom;
        emit_kind = htbd_pkg::KIND_END;
        emit_garb = empty || (walk_node != root);
      end
      htbd_pkg::ST_FINISH: flush_req = pend_valid;
      default: ;
    endcase
  end

  assign emit_fire  = emit_req && can_emit;
  assign flush_fire = flush_req && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= htbd_pkg::ST_IDLE;
      fvalid     <= '0;
      node_count <= '0;
      heap_size  <= '0;
      walk_node  <= '0;
      root       <= '0;
      tree_ready <= 1'b0;
      in_merge   <= 1'b0;
      pop_second <= 1'b0;
      pend_valid <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state    <= state_next;
      fvalid_q <= fvalid[f_raddr];
      if (f_we) begin
        fvalid[f_waddr] <= 1'b1;
      end

      // output register: load the held item, else drop a taken one
      if ((emit_fire && pend_valid) || flush_fire) begin
        rsp.valid          <= 1'b1;
        rsp.result_kind    <= pend_kind;
        rsp.decoded_symbol <= pend_sym;
        rsp.leaf_count     <= pend_leaves;
        rsp.garbage        <= pend_garb;
        rsp.last_of_run    <= flush_fire;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (emit_fire) begin
        pend_valid  <= 1'b1;
        pend_kind   <= emit_kind;
        pend_sym    <= emit_sym;
        pend_leaves <= emit_leaves;
        pend_garb   <= emit_garb;
      end else if (flush_fire) begin
        pend_valid <= 1'b0;
      end

      case (state)
        htbd_pkg::ST_IDLE: begin
          if (acc && req.opcode == htbd_pkg::OP_BUILD) begin
            s          <= (SW+1)'(1);
            node_count <= '0;
            heap_size  <= '0;
            leaves     <= '0;
            in_merge   <= 1'b0;
          end
          if (acc && req.opcode == htbd_pkg::OP_DECODE) begin
            dbits <= req.data_byte;
            dcnt  <= sat_bits;
            deom  <= req.end_of_message;
          end
        end
        htbd_pkg::ST_B_FCHK: begin
          if (fval != '0) begin
            pu_ent.w   <= WB'(fval);
            pu_ent.idx <= node_count;
            node_count <= node_count + NW'(1);
            leaves     <= leaves + SW'(1);
          end
        end
        htbd_pkg::ST_B_NEXT: begin
          s <= s + (SW+1)'(1);
          if (s == (SW+1)'(SYMBOLS - 1)) begin
            in_merge <= 1'b1;
          end
        end
        htbd_pkg::ST_PU_START: begin
          pu_i      <= heap_size + SW'(1);
          heap_size <= heap_size + SW'(1);
        end
        htbd_pkg::ST_PU_CMP: begin
          if (!par_le) begin
            pu_i <= pu_par;
          end
        end
        htbd_pkg::ST_M_CHK: begin
          pop_second <= 1'b0;
          if (heap_size == '0) begin
            tree_ready <= 1'b1;
            root       <= '0;
            walk_node  <= '0;
          end
        end
        htbd_pkg::ST_PO_TOP_RD: begin
          po_end    <= heap_size;
          heap_size <= heap_size - SW'(1);
          po_i      <= SW'(1);
        end
        htbd_pkg::ST_PO_TOP: po_top <= h_rdata;
        htbd_pkg::ST_PO_L: begin
          po_lent <= h_rdata;
          if (!right_lt) begin
            po_i <= l2[SW-1:0];
          end
        end
        htbd_pkg::ST_PO_R: begin
          po_i <= (h_rdata.w < po_lent.w) ? l2p1[SW-1:0] : l2[SW-1:0];
        end
        htbd_pkg::ST_PO_END: begin
          if (!pop_second) begin
            ent_a      <= po_top;
            pop_second <= 1'b1;
          end else begin
            ent_b <= po_top;
          end
        end
        htbd_pkg::ST_M_NODE: begin
          pu_ent.w   <= ent_a.w + ent_b.w;
          pu_ent.idx <= node_count;
          node_count <= node_count + NW'(1);
          pop_second <= 1'b0;
        end
        htbd_pkg::ST_B_HRT: root <= h_rdata.idx;
        htbd_pkg::ST_B_ROOT: begin
          root_rec   <= n_rdata;
          cur_rec    <= n_rdata;
          walk_node  <= root;
          tree_ready <= 1'b1;
        end
        htbd_pkg::ST_D_BIT: begin
          if (!empty && dcnt != '0) begin
            if (root_rec.leaf) begin
              // single-symbol tree: every bit lands on the root leaf
              if (can_emit) begin
                dbits     <= {dbits[6:0], 1'b0};
                dcnt      <= dcnt - 4'd1;
                walk_node <= root;
              end
            end else begin
              d_child <= child;
              dbits   <= {dbits[6:0], 1'b0};
              dcnt    <= dcnt - 4'd1;
            end
          end
        end
        htbd_pkg::ST_D_CHK: begin
          if (n_rdata.leaf) begin
            if (can_emit) begin
              walk_node <= root;
              cur_rec   <= root_rec;
            end
          end else begin
            walk_node <= d_child;
            cur_rec   <= n_rdata;
          end
        end
        htbd_pkg::ST_D_EOM: begin
          if (deom && can_emit) begin
            walk_node <= root;
            cur_rec   <= root_rec;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
